[design/ttsm_pkg.sv]
package ttsm_pkg;

	localparam int HISTORY_DEPTH = 20;
	localparam int TABLE_ENTRIES = 16;
	localparam int CHAR_BITS     = 16;

	localparam int CMD_W   = 2;
	localparam int ENTRY_W = 4;
	localparam int POS_W   = 5;
	localparam int LEN_W   = 5;

	localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
	localparam int ENT_IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RAM_DEPTH  = TABLE_ENTRIES * HISTORY_DEPTH;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);

	localparam logic [CMD_W-1:0] CMD_KEY       = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_CHR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE_LEN = 2'd2;

	localparam logic [CHAR_BITS-1:0] CODE_NONE      = CHAR_BITS'(0);
	localparam logic [CHAR_BITS-1:0] CODE_BACKSPACE = CHAR_BITS'(8);
	localparam logic [CHAR_BITS-1:0] CODE_THREE     = CHAR_BITS'(8'h33);
	localparam logic [CHAR_BITS-1:0] CODE_FOUR      = CHAR_BITS'(8'h34);
	localparam logic [CHAR_BITS-1:0] CODE_HASH      = CHAR_BITS'(8'h23);
	localparam logic [CHAR_BITS-1:0] CODE_DOLLAR    = CHAR_BITS'(8'h24);

	typedef struct packed {
		logic                 push;
		logic                 pop;
		logic                 clear;
		logic [CHAR_BITS-1:0] ch;
	} hist_ctl_t;

	function automatic logic [RAM_AW-1:0] ram_addr(
		input logic [ENT_IDX_W-1:0] entry,
		input logic [POS_W-1:0]     pos
	);
		logic [RAM_AW-1:0] row;
		row = RAM_AW'(entry) * RAM_AW'(HISTORY_DEPTH);
		return row + RAM_AW'(pos);
	endfunction

endpackage

[design/ttsm_ram.sv]
module ttsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/ttsm_hist.sv]
module ttsm_hist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ttsm_pkg::hist_ctl_t                 ctl,
	input  logic [ttsm_pkg::HIST_IDX_W-1:0]     rd_idx,
	output logic [ttsm_pkg::CHAR_BITS-1:0]      rd_char,
	output logic [ttsm_pkg::CNT_W-1:0]          count
);

	logic [ttsm_pkg::CHAR_BITS-1:0] hist_q [ttsm_pkg::HISTORY_DEPTH];
	logic [ttsm_pkg::CNT_W-1:0]     count_q;
	logic                           full;

	assign full = count_q >= ttsm_pkg::CNT_W'(ttsm_pkg::HISTORY_DEPTH);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (full) begin
				for (int k = 0; k < ttsm_pkg::HISTORY_DEPTH - 1; k++) begin
					hist_q[k] <= hist_q[k+1];
				end
				hist_q[ttsm_pkg::HISTORY_DEPTH-1] <= ctl.ch;
			end else begin
				hist_q[count_q[ttsm_pkg::HIST_IDX_W-1:0]] <= ctl.ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.push) begin
			if (!full) begin
				count_q <= count_q + ttsm_pkg::CNT_W'(1);
			end
		end else if (ctl.pop) begin
			if (count_q != '0) begin
				count_q <= count_q - ttsm_pkg::CNT_W'(1);
			end
		end
	end

	assign rd_char = hist_q[rd_idx];
	assign count   = count_q;

endmodule

[design/ttsm_seq.sv]
module ttsm_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ttsm_pkg::CMD_W-1:0]          command,
	input  logic [ttsm_pkg::CHAR_BITS-1:0]      char_code,
	input  logic                                shift_held,
	input  logic [ttsm_pkg::ENTRY_W-1:0]        entry_index,
	input  logic [ttsm_pkg::POS_W-1:0]          char_pos,
	input  logic [ttsm_pkg::LEN_W-1:0]          entry_length,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                matched,
	output logic [ttsm_pkg::ENTRY_W-1:0]        match_index,
	output logic [ttsm_pkg::LEN_W-1:0]          erase_count,
	output ttsm_pkg::hist_ctl_t                 hist_ctl,
	output logic [ttsm_pkg::HIST_IDX_W-1:0]     hist_idx,
	input  logic [ttsm_pkg::CHAR_BITS-1:0]      hist_char,
	input  logic [ttsm_pkg::CNT_W-1:0]          hist_count,
	output logic                                ram_we,
	output logic [ttsm_pkg::RAM_AW-1:0]         ram_waddr,
	output logic [ttsm_pkg::CHAR_BITS-1:0]      ram_wdata,
	output logic [ttsm_pkg::RAM_AW-1:0]         ram_raddr,
	input  logic [ttsm_pkg::CHAR_BITS-1:0]      ram_rdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ENTRY = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                       state_q;
	logic [ttsm_pkg::ENT_IDX_W-1:0]   ent_q;
	logic [ttsm_pkg::POS_W-1:0]       pos_q;
	logic [ttsm_pkg::LEN_W-1:0]       len_q;
	logic [ttsm_pkg::HIST_IDX_W-1:0]  base_q;
	logic [ttsm_pkg::LEN_W-1:0]       lens_q [ttsm_pkg::TABLE_ENTRIES];
	logic                             res_match_q;
	logic [ttsm_pkg::ENTRY_W-1:0]     res_idx_q;
	logic [ttsm_pkg::LEN_W-1:0]       res_len_q;
	logic                             out_valid_q;
	logic                             out_match_q;
	logic [ttsm_pkg::ENTRY_W-1:0]     out_idx_q;
	logic [ttsm_pkg::LEN_W-1:0]       out_len_q;

	logic                             accept;
	logic                             key_acc;
	logic                             entry_ok;
	logic [ttsm_pkg::ENT_IDX_W-1:0]   entry_sel;
	logic [ttsm_pkg::CHAR_BITS-1:0]   key_char;
	logic                             is_printable;
	logic [ttsm_pkg::LEN_W-1:0]       cur_len;
	logic                             skip_entry;
	logic                             last_entry;
	logic                             last_char;
	logic                             char_eq;
	logic                             out_free;
	logic [ttsm_pkg::POS_W-1:0]       rd_pos;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign key_acc  = accept && command == ttsm_pkg::CMD_KEY;
	assign entry_ok = {1'b0, entry_index} < (ttsm_pkg::ENTRY_W + 1)'(ttsm_pkg::TABLE_ENTRIES);
	assign entry_sel = ttsm_pkg::ENT_IDX_W'(entry_index);

	always_comb begin
		key_char = char_code;
		if (shift_held && char_code == ttsm_pkg::CODE_THREE) begin
			key_char = ttsm_pkg::CODE_HASH;
		end else if (shift_held && char_code == ttsm_pkg::CODE_FOUR) begin
			key_char = ttsm_pkg::CODE_DOLLAR;
		end
	end

	assign is_printable = char_code != ttsm_pkg::CODE_NONE
		&& char_code != ttsm_pkg::CODE_BACKSPACE;

	assign cur_len    = lens_q[ent_q];
	assign skip_entry = cur_len == '0 || ttsm_pkg::CNT_W'(cur_len) > hist_count;
	assign last_entry = ent_q == ttsm_pkg::ENT_IDX_W'(ttsm_pkg::TABLE_ENTRIES - 1);
	assign last_char  = pos_q == ttsm_pkg::POS_W'(len_q - ttsm_pkg::LEN_W'(1));
	assign hist_idx   = base_q + ttsm_pkg::HIST_IDX_W'(pos_q);
	assign char_eq    = ram_rdata == hist_char;
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		hist_ctl.push  = key_acc && is_printable;
		hist_ctl.pop   = key_acc && char_code == ttsm_pkg::CODE_BACKSPACE;
		hist_ctl.clear = state_q == ST_CMP && char_eq && last_char;
		hist_ctl.ch    = key_char;
	end

	assign ram_we    = accept && command == ttsm_pkg::CMD_WRITE_CHR && entry_ok
		&& char_pos < ttsm_pkg::POS_W'(ttsm_pkg::HISTORY_DEPTH);
	assign ram_waddr = ttsm_pkg::ram_addr(entry_sel, char_pos);
	assign ram_wdata = char_code;
	assign rd_pos    = (state_q == ST_CMP && !last_char) ? pos_q + ttsm_pkg::POS_W'(1) : '0;
	assign ram_raddr = ttsm_pkg::ram_addr(ent_q, rd_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ttsm_pkg::TABLE_ENTRIES; k++) begin
				lens_q[k] <= '0;
			end
		end else if (accept && command == ttsm_pkg::CMD_WRITE_LEN && entry_ok) begin
			lens_q[entry_sel] <= entry_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ent_q       <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			base_q      <= '0;
			res_match_q <= 1'b0;
			res_idx_q   <= '0;
			res_len_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (key_acc) begin
						res_match_q <= 1'b0;
						res_idx_q   <= '0;
						res_len_q   <= '0;
						ent_q       <= '0;
						state_q     <= is_printable ? ST_ENTRY : ST_DONE;
					end
				end
				ST_ENTRY: begin
					if (skip_entry) begin
						if (last_entry) begin
							state_q <= ST_DONE;
						end else begin
							ent_q <= ent_q + ttsm_pkg::ENT_IDX_W'(1);
						end
					end else begin
						len_q   <= cur_len;
						base_q  <= ttsm_pkg::HIST_IDX_W'(hist_count - ttsm_pkg::CNT_W'(cur_len));
						pos_q   <= '0;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!char_eq) begin
						if (last_entry) begin
							state_q <= ST_DONE;
						end else begin
							ent_q   <= ent_q + ttsm_pkg::ENT_IDX_W'(1);
							state_q <= ST_ENTRY;
						end
					end else if (last_char) begin
						res_match_q <= 1'b1;
						res_idx_q   <= ttsm_pkg::ENTRY_W'(ent_q);
						res_len_q   <= len_q;
						state_q     <= ST_DONE;
					end else begin
						pos_q <= pos_q + ttsm_pkg::POS_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_match_q <= res_match_q;
			out_idx_q   <= res_idx_q;
			out_len_q   <= res_len_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign matched     = out_match_q;
	assign match_index = out_idx_q;
	assign erase_count = out_len_q;

endmodule

[design/typed_trigger_suffix_matcher_unit.sv]
// Load commands (trigger character, trigger length) give no result and leave the sequencer idle.
// A key event with no character or backspace scans no entries: it goes from idle to the done state,
// and its result then enters the output register. A typed character scans the table entry by entry
// and compares each candidate trigger character by character through the trigger RAM read port.
// One item is in flight at a time; a finished result waits in the output register.
// Reset clears the history count, all trigger lengths and the sequencer; trigger RAM is not cleared.
module typed_trigger_suffix_matcher_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ttsm_pkg::CMD_W-1:0]          command,
	input  logic [ttsm_pkg::CHAR_BITS-1:0]      char_code,
	input  logic                                shift_held,
	input  logic [ttsm_pkg::ENTRY_W-1:0]        entry_index,
	input  logic [ttsm_pkg::POS_W-1:0]          char_pos,
	input  logic [ttsm_pkg::LEN_W-1:0]          entry_length,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                matched,
	output logic [ttsm_pkg::ENTRY_W-1:0]        match_index,
	output logic [ttsm_pkg::LEN_W-1:0]          erase_count
);

	ttsm_pkg::hist_ctl_t               hist_ctl;
	logic [ttsm_pkg::HIST_IDX_W-1:0]   hist_idx;
	logic [ttsm_pkg::CHAR_BITS-1:0]    hist_char;
	logic [ttsm_pkg::CNT_W-1:0]        hist_count;
	logic                              ram_we;
	logic [ttsm_pkg::RAM_AW-1:0]       ram_waddr;
	logic [ttsm_pkg::CHAR_BITS-1:0]    ram_wdata;
	logic [ttsm_pkg::RAM_AW-1:0]       ram_raddr;
	logic [ttsm_pkg::CHAR_BITS-1:0]    ram_rdata;

	ttsm_ram #(
		.WIDTH (ttsm_pkg::CHAR_BITS),
		.DEPTH (ttsm_pkg::RAM_DEPTH)
	) u_trig_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ttsm_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hist_ctl),
		.rd_idx  (hist_idx),
		.rd_char (hist_char),
		.count   (hist_count)
	);

	ttsm_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.char_code    (char_code),
		.shift_held   (shift_held),
		.entry_index  (entry_index),
		.char_pos     (char_pos),
		.entry_length (entry_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matched      (matched),
		.match_index  (match_index),
		.erase_count  (erase_count),
		.hist_ctl     (hist_ctl),
		.hist_idx     (hist_idx),
		.hist_char    (hist_char),
		.hist_count   (hist_count),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

endmodule
